>>> src/asv_pkg.sv
// ----------------------------------------------------------------------------
// asv_pkg
// Shared widths, register indexes and status codes for the arrive steering
// velocity block.
// ----------------------------------------------------------------------------
package asv_pkg;

  localparam int COORD_W = 32;
  localparam int REG_W   = 31;
  localparam int MAG_W   = 32;
  localparam int SUM_W   = 66;
  localparam int ROOT_W  = 33;
  localparam int QUO_W   = 31;
  localparam int IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    CFG_SPEED = 2'd0,
    CFG_STOP  = 2'd1,
    CFG_SLOW  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_ARRIVED = 2'd0,
    ST_SLOW    = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

endpackage

>>> src/asv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// asv_sqrt_cell
// One digit of the integer square root: tries one root bit, keeps the
// remainder and hands root, remainder and side data to the next cell.
// ----------------------------------------------------------------------------
module asv_sqrt_cell
  import asv_pkg::*;
#(
  parameter int BIT = 0,
  parameter int PW  = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SUM_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [PW-1:0]     pay_i,
  output logic              valid_o,
  output logic [SUM_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [PW-1:0]     pay_o
);

  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    rem_ext;
  logic              fit;
  logic [SUM_W-1:0]  rem_d;
  logic [ROOT_W-1:0] root_d;
  logic              valid_q;
  logic [SUM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [PW-1:0]     pay_q;

  always_comb begin
    rem_ext = {1'b0, rem_i};
    trial   = ({{(SUM_W + 1 - ROOT_W){1'b0}}, root_i} << (BIT + 1))
            + ((SUM_W + 1)'(1) << (2 * BIT));
    fit     = rem_ext >= trial;
    rem_d   = fit ? SUM_W'(rem_ext - trial) : rem_i;
    root_d  = fit ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

>>> src/asv_div_cell.sv
// ----------------------------------------------------------------------------
// asv_div_cell
// One step of restoring division: shifts in a numerator bit, subtracts the
// divisor when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module asv_div_cell #(
  parameter int DEN_W = 2,
  parameter int LOW_W = 2,
  parameter int PW    = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [LOW_W-1:0] low_i,
  input  logic [LOW_W-1:0] quo_i,
  input  logic [PW-1:0]    pay_i,
  output logic             valid_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [LOW_W-1:0] low_o,
  output logic [LOW_W-1:0] quo_o,
  output logic [PW-1:0]    pay_o
);

  logic [DEN_W:0]   trial;
  logic             fit;
  logic [DEN_W-1:0] rem_d;
  logic             valid_q;
  logic [DEN_W-1:0] rem_q;
  logic [LOW_W-1:0] low_q;
  logic [LOW_W-1:0] quo_q;
  logic [PW-1:0]    pay_q;

  always_comb begin
    trial = {rem_i, low_i[LOW_W-1]};
    fit   = trial >= {1'b0, den_i};
    rem_d = fit ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      low_q <= low_i << 1;
      quo_q <= {quo_i[LOW_W-2:0], fit};
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign low_o   = low_q;
  assign quo_o   = quo_q;
  assign pay_o   = pay_q;

endmodule

>>> src/arrive_steering_velocity.sv
// ----------------------------------------------------------------------------
// arrive_steering_velocity
// Arrive steering: scales the offset from current to target position to the
// desired velocity, slowing down inside the slow radius.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with current and target position
//   in signed Q16.16. Output channel: out_valid_o / out_stall_i with the
//   desired velocity and a status code (arrived, slowing, full speed).
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 speed, 1 stop radius, 2 slow radius); other indexes are dropped.
//   Write only while the block is empty.
// Timing:
//   One item per cycle while the skid register is empty. Stages in order:
//   offset, square and sum registers, 33 root cells, compare and scale
//   product register, 31 cells of the scale division, component product
//   register, 31 cells of the component divisions, output register.
// Reset: empties the pipeline; speed 1.0, both radii zero.
// Stall: a result held by out_stall_i stays on the output while the next
//   one moves into a skid register; the whole pipeline holds and in_stall_o
//   rises only while the skid register is full.
// ----------------------------------------------------------------------------
module arrive_steering_velocity
  import asv_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [IDX_W-1:0]          cfg_idx_i,
  input  logic [REG_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] cur_x_i,
  input  logic signed [COORD_W-1:0] cur_y_i,
  input  logic signed [COORD_W-1:0] cur_z_i,
  input  logic signed [COORD_W-1:0] tgt_x_i,
  input  logic signed [COORD_W-1:0] tgt_y_i,
  input  logic signed [COORD_W-1:0] tgt_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] vel_x_o,
  output logic signed [COORD_W-1:0] vel_y_o,
  output logic signed [COORD_W-1:0] vel_z_o,
  output logic [1:0]                status_o
);

  localparam int SPW = 3 * MAG_W + 3;
  localparam int APW = ROOT_W + 3 * MAG_W + 3 + 2;
  localparam int BPW = ROOT_W + 3;
  localparam int PRD_W = MAG_W + REG_W;

  logic [REG_W-1:0] speed_q, stop_q, slow_q;
  logic             en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= REG_W'(65536);
      stop_q  <= '0;
      slow_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPEED: speed_q <= cfg_wdata_i;
        CFG_STOP:  stop_q  <= cfg_wdata_i;
        CFG_SLOW:  slow_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // offset, square, sum
  logic [COORD_W:0]            dif [3];
  logic                        v1_q, v2_q, v3_q;
  logic [2:0][MAG_W-1:0]       mag1_q, mag2_q, mag3_q;
  logic [2:0]                  neg1_q, neg2_q, neg3_q;
  logic [2:0][2*MAG_W-1:0]     sq2_q;
  logic [SUM_W-1:0]            sum3_q;

  assign dif[0] = {tgt_x_i[COORD_W-1], tgt_x_i} - {cur_x_i[COORD_W-1], cur_x_i};
  assign dif[1] = {tgt_y_i[COORD_W-1], tgt_y_i} - {cur_y_i[COORD_W-1], cur_y_i};
  assign dif[2] = {tgt_z_i[COORD_W-1], tgt_z_i} - {cur_z_i[COORD_W-1], cur_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= dif[i][COORD_W];
        mag1_q[i] <= dif[i][COORD_W] ? MAG_W'(-dif[i]) : dif[i][MAG_W-1:0];
        sq2_q[i]  <= mag1_q[i] * mag1_q[i];
      end
      mag2_q <= mag1_q;
      neg2_q <= neg1_q;
      sum3_q <= SUM_W'(sq2_q[0]) + SUM_W'(sq2_q[1]) + SUM_W'(sq2_q[2]);
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
    end
  end

  // square root chain
  logic              s_v    [ROOT_W+1];
  logic [SUM_W-1:0]  s_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] s_root [ROOT_W+1];
  logic [SPW-1:0]    s_pay  [ROOT_W+1];

  assign s_v[0]    = v3_q;
  assign s_rem[0]  = sum3_q;
  assign s_root[0] = '0;
  assign s_pay[0]  = {mag3_q, neg3_q};

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    asv_sqrt_cell #(.BIT(ROOT_W - 1 - k), .PW(SPW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s_v[k]),
      .rem_i   (s_rem[k]),
      .root_i  (s_root[k]),
      .pay_i   (s_pay[k]),
      .valid_o (s_v[k+1]),
      .rem_o   (s_rem[k+1]),
      .root_o  (s_root[k+1]),
      .pay_o   (s_pay[k+1])
    );
  end

  // classify, scale product
  logic [ROOT_W-1:0] distance;
  status_e           st_d;
  logic              dv_q;
  logic [2*REG_W-1:0] dp_q;
  logic [APW-1:0]    dpay_q;

  assign distance = s_root[ROOT_W];

  always_comb begin
    if (distance == '0 || distance < {2'b0, stop_q}) begin
      st_d = ST_ARRIVED;
    end else if (distance < {2'b0, slow_q}) begin
      st_d = ST_SLOW;
    end else begin
      st_d = ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
    end else if (en) begin
      dv_q <= s_v[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp_q   <= speed_q * distance[REG_W-1:0];
      dpay_q <= {distance, s_pay[ROOT_W], 2'(st_d)};
    end
  end

  // scale division chain
  logic             a_v   [QUO_W+1];
  logic [REG_W-1:0] a_rem [QUO_W+1];
  logic [QUO_W-1:0] a_low [QUO_W+1];
  logic [QUO_W-1:0] a_quo [QUO_W+1];
  logic [APW-1:0]   a_pay [QUO_W+1];

  assign a_v[0]   = dv_q;
  assign a_rem[0] = dp_q[2*REG_W-1:QUO_W];
  assign a_low[0] = dp_q[QUO_W-1:0];
  assign a_quo[0] = '0;
  assign a_pay[0] = dpay_q;

  for (genvar k = 0; k < QUO_W; k++) begin : g_scale
    asv_div_cell #(.DEN_W(REG_W), .LOW_W(QUO_W), .PW(APW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (a_v[k]),
      .den_i   (slow_q),
      .rem_i   (a_rem[k]),
      .low_i   (a_low[k]),
      .quo_i   (a_quo[k]),
      .pay_i   (a_pay[k]),
      .valid_o (a_v[k+1]),
      .rem_o   (a_rem[k+1]),
      .low_o   (a_low[k+1]),
      .quo_o   (a_quo[k+1]),
      .pay_o   (a_pay[k+1])
    );
  end

  // component products
  logic [APW-1:0]        apay;
  status_e               a_st;
  logic [REG_W-1:0]      scale;
  logic                  ev_q;
  logic [2:0][PRD_W-1:0] prod_q;
  logic [2:0][BPW-1:0]   epay_q;

  assign apay  = a_pay[QUO_W];
  assign a_st  = status_e'(apay[1:0]);
  assign scale = (a_st == ST_SLOW) ? a_quo[QUO_W] : speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
    end else if (en) begin
      ev_q <= a_v[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= apay[5 + MAG_W*i +: MAG_W] * scale;
        epay_q[i] <= {apay[APW-1 -: ROOT_W], apay[1:0], apay[2+i]};
      end
    end
  end

  // component division chains
  logic              b_v   [3][QUO_W+1];
  logic [ROOT_W-1:0] b_rem [3][QUO_W+1];
  logic [QUO_W-1:0]  b_low [3][QUO_W+1];
  logic [QUO_W-1:0]  b_quo [3][QUO_W+1];
  logic [BPW-1:0]    b_pay [3][QUO_W+1];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    assign b_v[c][0]   = ev_q;
    assign b_rem[c][0] = {1'b0, prod_q[c][PRD_W-1:QUO_W]};
    assign b_low[c][0] = prod_q[c][QUO_W-1:0];
    assign b_quo[c][0] = '0;
    assign b_pay[c][0] = epay_q[c];

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      asv_div_cell #(.DEN_W(ROOT_W), .LOW_W(QUO_W), .PW(BPW)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (b_v[c][k]),
        .den_i   (b_pay[c][k][BPW-1 -: ROOT_W]),
        .rem_i   (b_rem[c][k]),
        .low_i   (b_low[c][k]),
        .quo_i   (b_quo[c][k]),
        .pay_i   (b_pay[c][k]),
        .valid_o (b_v[c][k+1]),
        .rem_o   (b_rem[c][k+1]),
        .low_o   (b_low[c][k+1]),
        .quo_o   (b_quo[c][k+1]),
        .pay_o   (b_pay[c][k+1])
      );
    end
  end

  // final sign and output skid
  logic                    lv;
  status_e                 l_st;
  logic [2:0][COORD_W-1:0] lvel;

  assign lv   = b_v[0][QUO_W] & b_v[1][QUO_W] & b_v[2][QUO_W];
  assign l_st = status_e'(b_pay[0][QUO_W][2:1]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (l_st == ST_ARRIVED) begin
        lvel[i] = '0;
      end else if (b_pay[i][QUO_W][0]) begin
        lvel[i] = -{1'b0, b_quo[i][QUO_W]};
      end else begin
        lvel[i] = {1'b0, b_quo[i][QUO_W]};
      end
    end
  end

  logic                    out_v_q, skid_v_q;
  logic [2:0][COORD_W-1:0] out_vel_q, skid_vel_q;
  status_e                 out_st_q, skid_st_q;

  assign en = !skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !out_stall_i) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= lv;
      end
    end else if (!out_v_q) begin
      out_v_q <= lv;
    end else if (lv && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((out_v_q && !out_stall_i) || !out_v_q) begin
      if (skid_v_q) begin
        out_vel_q <= skid_vel_q;
        out_st_q  <= skid_st_q;
      end else begin
        out_vel_q <= lvel;
        out_st_q  <= l_st;
      end
    end else if (en) begin
      skid_vel_q <= lvel;
      skid_st_q  <= l_st;
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign vel_x_o     = out_vel_q[0];
  assign vel_y_o     = out_vel_q[1];
  assign vel_z_o     = out_vel_q[2];
  assign status_o    = 2'(out_st_q);

endmodule
